// ----- hw/rtl/tracker_beacon_duty_cycle_sequencer_macros.svh -----
// assertion helpers, included by the engine
`ifndef TRACKER_BEACON_DUTY_CYCLE_SEQUENCER_MACROS_SVH
`define TRACKER_BEACON_DUTY_CYCLE_SEQUENCER_MACROS_SVH
`ifndef SYNTHESIS
`define TBDCS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define TBDCS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define TBDCS_ASSERT(label, clk, rst, prop, msg)
`define TBDCS_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- hw/rtl/tbdcs_pkg.sv -----
`default_nettype none

package tbdcs_pkg;

  localparam int CALIB_FIXES = 4;
  localparam int CALIB_CNT_W = 4;
  localparam logic [CALIB_CNT_W-1:0] CALIB_DONE = CALIB_CNT_W'(CALIB_FIXES);

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes of the configuration port
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPEED_THRESHOLD  = 3'd0,
    CFG_MOVE_INTERVAL    = 3'd1,
    CFG_REST_INTERVAL    = 3'd2,
    CFG_FIX_TIMEOUT      = 3'd3,
    CFG_CALIB_TIMEOUT    = 3'd4,
    CFG_RETRY_LIMIT      = 3'd5,
    CFG_BUTTON_TX_ENABLE = 3'd6
  } cfg_index_e;

  localparam logic [15:0] SPEED_THRESHOLD_RST = 16'd500;
  localparam logic [31:0] MOVE_INTERVAL_RST   = 32'd300000;
  localparam logic [31:0] REST_INTERVAL_RST   = 32'd3600000;
  localparam logic [31:0] FIX_TIMEOUT_RST     = 32'd60000;
  localparam logic [31:0] CALIB_TIMEOUT_RST   = 32'd900000;
  localparam logic [3:0]  RETRY_LIMIT_RST     = 4'd3;

  localparam logic [31:0] PAUSE_FIRST_MS  = 32'd180000;
  localparam logic [31:0] PAUSE_SECOND_MS = 32'd120000;
  localparam logic [31:0] PAUSE_LAST_MS   = 32'd60000;

  typedef struct packed {
    logic [15:0] speed_threshold;
    logic [31:0] move_interval_ms;
    logic [31:0] rest_interval_ms;
    logic [31:0] fix_timeout_ms;
    logic [31:0] calib_timeout_ms;
    logic [3:0]  retry_limit;
    logic        button_tx_enable;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        fix_valid;
    logic        fix_updated;
    logic [15:0] speed_centi_kmph;
    logic        radio_ready;
    logic        send_ok;
    logic        button_press;
  } poll_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic        gps_power;
    logic        transmit_strobe;
    logic [31:0] sleep_remaining_ms;
    logic [2:0]  calib_reads;
    logic [3:0]  retry_count;
  } result_t;

  // pause after the n-th calibration fix, last entry reused beyond the table
  function automatic logic [31:0] pause_ms(input logic [CALIB_CNT_W-1:0] count);
    logic [31:0] val;
    if (count <= CALIB_CNT_W'(1)) begin
      val = PAUSE_FIRST_MS;
    end else if (count == CALIB_CNT_W'(2)) begin
      val = PAUSE_SECOND_MS;
    end else begin
      val = PAUSE_LAST_MS;
    end
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tbdcs_if.sv -----
`default_nettype none

interface tbdcs_poll_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic        fix_valid;
  logic        fix_updated;
  logic [15:0] speed_centi_kmph;
  logic        radio_ready;
  logic        send_ok;
  logic        button_press;

  modport source (output valid, now_ms, fix_valid, fix_updated, speed_centi_kmph,
                  radio_ready, send_ok, button_press, input ready);
  modport sink   (input valid, now_ms, fix_valid, fix_updated, speed_centi_kmph,
                  radio_ready, send_ok, button_press, output ready);
endinterface

interface tbdcs_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        gps_power;
  logic        transmit_strobe;
  logic [31:0] sleep_remaining_ms;
  logic [2:0]  calib_reads;
  logic [3:0]  retry_count;

  modport source (output valid, mode, gps_power, transmit_strobe, sleep_remaining_ms,
                  calib_reads, retry_count, input ready);
  modport sink   (input valid, mode, gps_power, transmit_strobe, sleep_remaining_ms,
                  calib_reads, retry_count, output ready);
endinterface

interface tbdcs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tbdcs_pkg::CFG_INDEX_W-1:0] index;
  logic [tbdcs_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tbdcs_cfg_regs.sv -----
`default_nettype none

module tbdcs_cfg_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  tbdcs_cfg_if.sink        cfg,
  output tbdcs_pkg::cfg_t  regs
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.speed_threshold  <= tbdcs_pkg::SPEED_THRESHOLD_RST;
      regs.move_interval_ms <= tbdcs_pkg::MOVE_INTERVAL_RST;
      regs.rest_interval_ms <= tbdcs_pkg::REST_INTERVAL_RST;
      regs.fix_timeout_ms   <= tbdcs_pkg::FIX_TIMEOUT_RST;
      regs.calib_timeout_ms <= tbdcs_pkg::CALIB_TIMEOUT_RST;
      regs.retry_limit      <= tbdcs_pkg::RETRY_LIMIT_RST;
      regs.button_tx_enable <= 1'b0;
    end else if (cfg.valid) begin
      unique case (tbdcs_pkg::cfg_index_e'(cfg.index))
        tbdcs_pkg::CFG_SPEED_THRESHOLD:  regs.speed_threshold  <= cfg.data[15:0];
        tbdcs_pkg::CFG_MOVE_INTERVAL:    regs.move_interval_ms <= cfg.data;
        tbdcs_pkg::CFG_REST_INTERVAL:    regs.rest_interval_ms <= cfg.data;
        tbdcs_pkg::CFG_FIX_TIMEOUT:      regs.fix_timeout_ms   <= cfg.data;
        tbdcs_pkg::CFG_CALIB_TIMEOUT:    regs.calib_timeout_ms <= cfg.data;
        tbdcs_pkg::CFG_RETRY_LIMIT:      regs.retry_limit      <= cfg.data[3:0];
        tbdcs_pkg::CFG_BUTTON_TX_ENABLE: regs.button_tx_enable <= cfg.data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tbdcs_engine.sv -----
`default_nettype none
`include "tracker_beacon_duty_cycle_sequencer_macros.svh"

module tbdcs_engine (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              go,
  input  wire tbdcs_pkg::poll_t  item,
  input  wire tbdcs_pkg::cfg_t   cfg,
  output tbdcs_pkg::result_t     res_next
);

  typedef enum logic [2:0] {
    MODE_CALIB   = 3'd0,
    MODE_POWERUP = 3'd1,
    MODE_SENSING = 3'd2,
    MODE_BUILD   = 3'd3,
    MODE_TX      = 3'd4,
    MODE_SLEEP   = 3'd5,
    MODE_RETRY   = 3'd6
  } mode_e;

  localparam int CW = tbdcs_pkg::CALIB_CNT_W;

  mode_e         cur_mode, cur_mode_next;
  mode_e         failed_mode, failed_mode_next;
  logic [3:0]    failures, failures_next;
  logic [31:0]   sleep_interval, sleep_interval_next;
  logic [31:0]   sleep_start, sleep_start_next;
  logic          sleep_begun, sleep_begun_next;
  logic [31:0]   powerup_start, powerup_start_next;
  logic          powerup_begun, powerup_begun_next;
  logic          calib_begun, calib_begun_next;
  logic [CW-1:0] calib_count, calib_count_next;
  logic [31:0]   calib_total_start, calib_total_start_next;
  logic [31:0]   calib_wait_start, calib_wait_start_next;
  logic          calib_awaiting_fix, calib_awaiting_fix_next;
  logic          calib_pausing, calib_pausing_next;
  logic          wake_request, wake_request_next;
  logic          gps_enabled, gps_enabled_next;

  logic          fresh_fix;
  logic          wake_eff;
  logic [31:0]   base_start;
  logic [31:0]   elapsed;
  logic [31:0]   wait_base;
  logic [31:0]   wait_elapsed;
  logic [CW-1:0] count_eff;
  logic [CW-1:0] count_inc;
  logic [3:0]    failures_inc;
  logic          strobe;
  logic [31:0]   remaining;

  assign fresh_fix    = item.fix_valid & item.fix_updated;
  assign wake_eff     = wake_request | (item.button_press & cfg.button_tx_enable);
  assign count_eff    = calib_begun ? calib_count : '0;
  assign count_inc    = count_eff + CW'(1);
  assign failures_inc = failures + 4'd1;
  assign wait_base    = calib_begun ? calib_wait_start : item.now_ms;
  assign wait_elapsed = item.now_ms - wait_base;

  // calib and power-up own starts; the rest use sleep's
  always_comb begin
    case (cur_mode)
      MODE_CALIB:   base_start = calib_begun ? calib_total_start : item.now_ms;
      MODE_POWERUP: base_start = powerup_begun ? powerup_start : item.now_ms;
      default:      base_start = sleep_begun ? sleep_start : item.now_ms;
    endcase
  end
  assign elapsed = item.now_ms - base_start;

  always_comb begin
    cur_mode_next           = cur_mode;
    failed_mode_next        = failed_mode;
    failures_next           = failures;
    sleep_interval_next     = sleep_interval;
    sleep_start_next        = sleep_start;
    sleep_begun_next        = sleep_begun;
    powerup_start_next      = powerup_start;
    powerup_begun_next      = powerup_begun;
    calib_begun_next        = calib_begun;
    calib_count_next        = calib_count;
    calib_total_start_next  = calib_total_start;
    calib_wait_start_next   = calib_wait_start;
    calib_awaiting_fix_next = calib_awaiting_fix;
    calib_pausing_next      = calib_pausing;
    wake_request_next       = wake_eff;
    gps_enabled_next        = gps_enabled;
    strobe                  = 1'b0;
    remaining               = '0;

    unique case (cur_mode)
      MODE_CALIB: begin
        calib_begun_next       = 1'b1;
        calib_total_start_next = base_start;
        calib_wait_start_next  = wait_base;
        calib_count_next       = count_eff;
        if (elapsed > cfg.calib_timeout_ms) begin
          cur_mode_next    = MODE_SLEEP;
          calib_begun_next = 1'b0;
        end else if (calib_awaiting_fix) begin
          if (fresh_fix) begin
            calib_count_next = count_inc;
            if (count_inc >= tbdcs_pkg::CALIB_DONE) begin
              cur_mode_next    = MODE_SLEEP;
              calib_begun_next = 1'b0;
            end else begin
              calib_awaiting_fix_next = 1'b0;
              calib_pausing_next      = 1'b1;
              calib_wait_start_next   = item.now_ms;
            end
          end
        end else if (calib_pausing) begin
          if (wait_elapsed >= tbdcs_pkg::pause_ms(count_eff)) begin
            calib_pausing_next      = 1'b0;
            calib_awaiting_fix_next = 1'b1;
            calib_wait_start_next   = item.now_ms;
          end
        end
      end
      MODE_POWERUP: begin
        gps_enabled_next   = 1'b1;
        powerup_begun_next = 1'b1;
        powerup_start_next = base_start;
        if (fresh_fix) begin
          powerup_begun_next = 1'b0;
          powerup_start_next = '0;
          cur_mode_next      = MODE_SENSING;
        end else if (elapsed > cfg.fix_timeout_ms) begin
          powerup_begun_next = 1'b0;
          powerup_start_next = '0;
          failed_mode_next   = MODE_POWERUP;
          cur_mode_next      = MODE_RETRY;
        end
      end
      MODE_SENSING: begin
        if (!item.fix_valid) begin
          failed_mode_next = MODE_SENSING;
          cur_mode_next    = MODE_RETRY;
        end else begin
          cur_mode_next = MODE_BUILD;
        end
      end
      MODE_BUILD: begin
        sleep_interval_next = (item.speed_centi_kmph > cfg.speed_threshold) ?
                              cfg.move_interval_ms : cfg.rest_interval_ms;
        cur_mode_next       = MODE_TX;
      end
      MODE_TX: begin
        gps_enabled_next = 1'b0;
        if (!item.radio_ready) begin
          failed_mode_next = MODE_TX;
          cur_mode_next    = MODE_RETRY;
        end else begin
          strobe = 1'b1;
          if (item.send_ok) begin
            cur_mode_next = MODE_SLEEP;
          end else begin
            failed_mode_next = MODE_TX;
            cur_mode_next    = MODE_RETRY;
          end
        end
      end
      MODE_SLEEP: begin
        sleep_start_next = base_start;
        sleep_begun_next = 1'b1;
        if (!sleep_begun) begin
          failures_next = '0;
        end
        remaining = sleep_interval - elapsed;
        if (elapsed >= sleep_interval || wake_eff) begin
          wake_request_next = 1'b0;
          sleep_begun_next  = 1'b0;
          cur_mode_next     = MODE_POWERUP;
        end
      end
      MODE_RETRY: begin
        if (failures_inc < cfg.retry_limit) begin
          failures_next = failures_inc;
          cur_mode_next = failed_mode;
        end else begin
          sleep_interval_next = cfg.rest_interval_ms;
          failures_next       = '0;
          cur_mode_next       = MODE_SLEEP;
        end
      end
      default: ;
    endcase

    res_next.mode               = cur_mode_next;
    res_next.gps_power          = gps_enabled_next;
    res_next.transmit_strobe    = strobe;
    res_next.sleep_remaining_ms = remaining;
    res_next.calib_reads        = calib_count_next[2:0];
    res_next.retry_count        = failures_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode           <= MODE_CALIB;
      failed_mode        <= MODE_POWERUP;
      failures           <= '0;
      sleep_interval     <= tbdcs_pkg::REST_INTERVAL_RST;
      sleep_start        <= '0;
      sleep_begun        <= 1'b0;
      powerup_start      <= '0;
      powerup_begun      <= 1'b0;
      calib_begun        <= 1'b0;
      calib_count        <= '0;
      calib_total_start  <= '0;
      calib_wait_start   <= '0;
      calib_awaiting_fix <= 1'b1;
      calib_pausing      <= 1'b0;
      wake_request       <= 1'b1;
      gps_enabled        <= 1'b1;
    end else if (go) begin
      cur_mode           <= cur_mode_next;
      failed_mode        <= failed_mode_next;
      failures           <= failures_next;
      sleep_interval     <= sleep_interval_next;
      sleep_start        <= sleep_start_next;
      sleep_begun        <= sleep_begun_next;
      powerup_start      <= powerup_start_next;
      powerup_begun      <= powerup_begun_next;
      calib_begun        <= calib_begun_next;
      calib_count        <= calib_count_next;
      calib_total_start  <= calib_total_start_next;
      calib_wait_start   <= calib_wait_start_next;
      calib_awaiting_fix <= calib_awaiting_fix_next;
      calib_pausing      <= calib_pausing_next;
      wake_request       <= wake_request_next;
      gps_enabled        <= gps_enabled_next;
    end
  end

  `TBDCS_ASSERT(a_calib_count_bound, clk, rst, calib_count <= tbdcs_pkg::CALIB_DONE, "calibration count past its end")
  `TBDCS_ASSERT(a_sleep_exit, clk, rst, go && cur_mode == MODE_SLEEP |=> cur_mode == MODE_SLEEP || cur_mode == MODE_POWERUP, "sleep left to a mode other than power-up")
  `TBDCS_ASSERT(a_strobe_next_mode, clk, rst, go && strobe |=> cur_mode == MODE_SLEEP || cur_mode == MODE_RETRY, "transmit not followed by sleep or retry")
  `TBDCS_ASSERT_NEVER(a_strobe_gps_on, clk, rst, go && strobe && gps_enabled_next, "gps powered during transmit")
  `TBDCS_ASSERT(a_hold_when_idle, clk, rst, !go |=> $stable(cur_mode) && $stable(failures), "state moved without a poll")

endmodule

`default_nettype wire

// ----- hw/rtl/tracker_beacon_duty_cycle_sequencer.sv -----
// Beacon duty-cycle sequencer. Every poll transfer on the poll channel (timestamp, gps fix
// flags, speed, radio status, button) steps a seven-mode machine (calibration, gps power-up,
// sensing, interval build, transmit, sleep, retry) and yields exactly one result transfer
// carrying the new mode, the gps supply enable, a transmit strobe, the remaining sleep time
// (zero outside sleep), the calibration fix count and the failure count. A poll is taken
// every cycle while the result channel does not stall; its result passes the input register,
// then the single-pass mode logic (one pass of subtract-and-compare logic against the mode
// state) into the result register, from which it is offered. A stalled result holds the result
// register, and only an empty input register takes one more poll. Registers on the config
// channel (index 0..6: speed threshold, move interval, rest interval, fix timeout,
// calibration timeout, retry limit, button wake enable) reset to 500, 300000, 3600000,
// 60000, 900000, 3 and 0; the user must see that they are written while the block is
// idle, which the block itself does not enforce. All time differences wrap modulo 2^32.
`default_nettype none

module tracker_beacon_duty_cycle_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  tbdcs_poll_if.sink       poll,
  tbdcs_result_if.source   result,
  tbdcs_cfg_if.sink        cfg
);

  tbdcs_pkg::cfg_t    cfg_regs;
  tbdcs_pkg::poll_t   in_item;
  logic               in_valid;
  tbdcs_pkg::result_t res;
  tbdcs_pkg::result_t res_next;
  logic               res_valid;
  logic               advance;
  logic               go;

  // config register file
  tbdcs_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (cfg_regs)
  );

  // result register moves when empty or when its transfer completes
  assign advance    = !res_valid || result.ready;
  // the held poll is evaluated whenever the result register can take it
  assign go         = in_valid && advance;
  // input register frees up as soon as its poll is evaluated
  assign poll.ready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (poll.ready) begin
      in_valid <= poll.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (poll.ready && poll.valid) begin
      in_item.now_ms           <= poll.now_ms;
      in_item.fix_valid        <= poll.fix_valid;
      in_item.fix_updated      <= poll.fix_updated;
      in_item.speed_centi_kmph <= poll.speed_centi_kmph;
      in_item.radio_ready      <= poll.radio_ready;
      in_item.send_ok          <= poll.send_ok;
      in_item.button_press     <= poll.button_press;
    end
  end

  // mode state and next-state logic
  tbdcs_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .go       (go),
    .item     (in_item),
    .cfg      (cfg_regs),
    .res_next (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      res <= res_next;
    end
  end

  assign result.valid              = res_valid;
  assign result.mode               = res.mode;
  assign result.gps_power          = res.gps_power;
  assign result.transmit_strobe    = res.transmit_strobe;
  assign result.sleep_remaining_ms = res.sleep_remaining_ms;
  assign result.calib_reads        = res.calib_reads;
  assign result.retry_count        = res.retry_count;

endmodule

`default_nettype wire
